// ----- sv/pnm_pkg.sv -----
// Shared constants, codes and result type of the PNM stream parser.
`timescale 1ns / 1ps

package pnm_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int COMP_BITS = 16;

    // Saturation limits for decimal fields, held in the 17-bit accumulator
    localparam logic [16:0] DIM_CAP  = 17'(MAX_DIM + 1);
    localparam logic [16:0] COMP_CAP = 17'((1 << COMP_BITS) - 1);

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PIX_BIT  = 2'd0,
        PIX_GRAY = 2'd1,
        PIX_RGB  = 2'd2
    } pix_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_MAGIC = 2'd1,
        ERR_DIMS  = 2'd2
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] col;
        logic [11:0] row;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        pix_t        pix;
        logic [12:0] width;
        logic [12:0] height;
        logic [15:0] max_comp;
        err_t        err;
        logic        last;
    } result_t;

endpackage

// ----- sv/pnm_byte_if.sv -----
// Input channel: one file byte per word.
`timescale 1ns / 1ps

interface pnm_byte_if;
    logic       valid;
    logic       ready;
    logic       start_of_file;
    logic [7:0] data_byte;

    modport source (output valid, output start_of_file, output data_byte, input ready);
    modport sink   (input valid, input start_of_file, input data_byte, output ready);
endinterface

// ----- sv/pnm_result_if.sv -----
// Output channel: one parse result per word.
`timescale 1ns / 1ps

interface pnm_result_if
    import pnm_pkg::*;
;
    logic        valid;
    logic        ready;
    kind_t       result_kind;
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    pix_t        pixel_type;
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] max_component;
    err_t        err_code;
    logic        last;

    modport source (
        output valid, output result_kind, output col, output row,
        output red, output green, output blue, output pixel_type,
        output width, output height, output max_component,
        output err_code, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input col, input row,
        input red, input green, input blue, input pixel_type,
        input width, input height, input max_component,
        input err_code, input last, output ready
    );
endinterface

// ----- sv/pnm_image_stream_parser_unit.sv -----
// PNM (P1..P6) byte stream parser: header decode and pixel emission.
`timescale 1ns / 1ps

// Takes a PNM file one byte per word and returns a header-complete word, then one word
// per pixel with its column and row, or an error word on a bad magic or dimension line.
// A byte is held in an input register and then decoded into an output register; one byte
// per cycle is sustained while the output is not stalled, except for raw bit (P4) bytes.
// The single output register carries one result per cycle when not stalled: a raw bit
// byte holds its input register until it has yielded its pixels, up to eight, fewer when
// the image ends within it. Bytes that yield no result still wait for a free output register.

module pnm_image_stream_parser_unit
    import pnm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pnm_byte_if.sink      bytes,
    pnm_result_if.source  results
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_DIMS,
        PH_MAX,
        PH_PIX,
        PH_DONE,
        PH_ERR
    } phase_t;

    // input register
    logic        in_valid_reg;
    logic        in_sof_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    phase_t      phase_reg,    phase_next;
    pix_t        fmt_reg,      fmt_next;
    logic        ascii_reg,    ascii_next;
    logic        comment_reg,  comment_next;
    logic [1:0]  line_len_reg, line_len_next;
    logic [7:0]  magic2_reg,   magic2_next;
    logic        magic_bad_reg, magic_bad_next;
    logic        space_reg,    space_next;
    logic [16:0] acc_reg,      acc_next;
    logic [12:0] img_w_reg,    img_w_next;
    logic [12:0] img_h_reg,    img_h_next;
    logic [15:0] max_reg,      max_next;
    logic [11:0] col_reg,      col_next;
    logic [12:0] row_reg,      row_next;
    logic [1:0]  comp_reg,     comp_next;
    logic [15:0] held_r_reg,   held_r_next;
    logic [15:0] held_g_reg,   held_g_next;
    logic [2:0]  bit_reg,      bit_next;

    // output register
    logic        out_valid_reg;
    result_t     res_reg;

    logic        step;
    logic        item_done;
    logic        res_fire;
    result_t     res;

    function automatic logic [16:0] acc_digit(input logic [16:0] acc, input logic [7:0] b,
                                              input logic [16:0] cap);
        logic [20:0] sum;
        sum = 21'({acc, 3'b000}) + 21'({acc, 1'b0}) + 21'(b[3:0]);
        if (b < CH_ZERO || b > CH_NINE)
            return acc;
        else if (sum > 21'(cap))
            return cap;
        else
            return sum[16:0];
    endfunction

    assign step = in_valid_reg && (!out_valid_reg || results.ready);

    always_comb
    begin
        logic [7:0]  b;
        logic        p4raw;
        logic        take;
        logic [15:0] sample;
        logic        emit;
        logic [15:0] pr;
        logic [15:0] pg;
        logic [15:0] pb;
        logic [12:0] col_inc;
        logic [12:0] row_inc;

        b       = in_byte_reg;
        p4raw   = 1'b0;
        take    = 1'b0;
        sample  = '0;
        emit    = 1'b0;
        pr      = '0;
        pg      = '0;
        pb      = '0;
        col_inc = '0;
        row_inc = '0;

        phase_next     = phase_reg;
        fmt_next       = fmt_reg;
        ascii_next     = ascii_reg;
        comment_next   = comment_reg;
        line_len_next  = line_len_reg;
        magic2_next    = magic2_reg;
        magic_bad_next = magic_bad_reg;
        space_next     = space_reg;
        acc_next       = acc_reg;
        img_w_next     = img_w_reg;
        img_h_next     = img_h_reg;
        max_next       = max_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        comp_next      = comp_reg;
        held_r_next    = held_r_reg;
        held_g_next    = held_g_reg;
        bit_next       = bit_reg;
        res            = '0;
        res_fire       = 1'b0;
        item_done      = 1'b0;

        if (step)
        begin
            if (in_sof_reg)
            begin
                phase_next     = PH_MAGIC;
                fmt_next       = PIX_BIT;
                ascii_next     = 1'b0;
                comment_next   = 1'b0;
                line_len_next  = '0;
                magic2_next    = '0;
                magic_bad_next = 1'b0;
                space_next     = 1'b0;
                acc_next       = '0;
                img_w_next     = '0;
                img_h_next     = '0;
                max_next       = '0;
                col_next       = '0;
                row_next       = '0;
                comp_next      = '0;
                held_r_next    = '0;
                held_g_next    = '0;
            end

            if (phase_next == PH_MAGIC || phase_next == PH_DIMS || phase_next == PH_MAX)
            begin
                if (b == CH_LF)
                begin
                    if (!comment_next)
                    begin
                        unique case (phase_next)
                            PH_MAGIC:
                            begin
                                if (magic_bad_next || line_len_next != 2'd2 ||
                                    magic2_next < CH_ONE || magic2_next > CH_SIX)
                                begin
                                    res.kind   = KIND_ERROR;
                                    res.err    = ERR_MAGIC;
                                    res_fire   = 1'b1;
                                    phase_next = PH_ERR;
                                end
                                else
                                begin
                                    unique case (magic2_next)
                                        CH_ONE, CH_FOUR: fmt_next = PIX_BIT;
                                        CH_ONE + 8'd1, CH_FIVE: fmt_next = PIX_GRAY;
                                        CH_THREE, CH_SIX: fmt_next = PIX_RGB;
                                        default: fmt_next = PIX_BIT;
                                    endcase
                                    ascii_next = (magic2_next <= CH_THREE);
                                    phase_next = PH_DIMS;
                                end
                            end
                            PH_DIMS:
                            begin
                                if (!space_next || img_w_next == '0 ||
                                    img_w_next > 13'(MAX_DIM) || acc_next == '0 ||
                                    acc_next > 17'(MAX_DIM))
                                begin
                                    res.kind   = KIND_ERROR;
                                    res.err    = ERR_DIMS;
                                    res_fire   = 1'b1;
                                    phase_next = PH_ERR;
                                end
                                else
                                begin
                                    img_h_next = acc_next[12:0];
                                    if (fmt_next == PIX_BIT)
                                    begin
                                        max_next   = '0;
                                        phase_next = PH_PIX;
                                        col_next   = '0;
                                        row_next   = '0;
                                        comp_next  = '0;
                                        res.kind   = KIND_HEADER;
                                        res_fire   = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_MAX;
                                    end
                                end
                            end
                            default:
                            begin
                                max_next   = acc_next[15:0];
                                phase_next = PH_PIX;
                                col_next   = '0;
                                row_next   = '0;
                                comp_next  = '0;
                                res.kind   = KIND_HEADER;
                                res_fire   = 1'b1;
                            end
                        endcase
                    end
                    comment_next   = 1'b0;
                    line_len_next  = '0;
                    magic_bad_next = 1'b0;
                    space_next     = 1'b0;
                    acc_next       = '0;
                end
                else
                begin
                    if (line_len_next == 2'd0 && b == CH_HASH)
                        comment_next = 1'b1;
                    if (!comment_next)
                    begin
                        unique case (phase_next)
                            PH_MAGIC:
                            begin
                                if (line_len_next == 2'd0 && b != CH_P)
                                    magic_bad_next = 1'b1;
                                if (line_len_next == 2'd1)
                                    magic2_next = b;
                            end
                            PH_DIMS:
                            begin
                                if (b == CH_SPACE)
                                begin
                                    // only the first space splits width from height
                                    if (!space_next)
                                    begin
                                        img_w_next = acc_next[12:0];
                                        acc_next   = '0;
                                        space_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    acc_next = acc_digit(acc_next, b, DIM_CAP);
                                end
                            end
                            default: acc_next = acc_digit(acc_next, b, COMP_CAP);
                        endcase
                    end
                    if (line_len_next != 2'd3)
                        line_len_next = line_len_next + 2'd1;
                end
                item_done = 1'b1;
            end
            else if (phase_next == PH_PIX)
            begin
                if (fmt_next == PIX_BIT)
                begin
                    if (ascii_next)
                    begin
                        if (b != CH_LF)
                        begin
                            emit = 1'b1;
                            pr   = (b == CH_ONE) ? 16'd0 : 16'd1;
                        end
                    end
                    else
                    begin
                        // MSB first, one pixel per cycle while the output is not stalled
                        p4raw = 1'b1;
                        emit  = 1'b1;
                        pr    = b[bit_reg] ? 16'd0 : 16'd1;
                    end
                end
                else if (ascii_next)
                begin
                    if (b == CH_LF)
                    begin
                        take     = 1'b1;
                        sample   = acc_next[15:0];
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = acc_digit(acc_next, b, COMP_CAP);
                    end
                end
                else
                begin
                    take   = 1'b1;
                    sample = {8'h00, b};
                end

                if (take)
                begin
                    if (fmt_next == PIX_RGB)
                    begin
                        unique case (comp_next)
                            2'd0:
                            begin
                                held_r_next = sample;
                                comp_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                held_g_next = sample;
                                comp_next   = 2'd2;
                            end
                            default:
                            begin
                                comp_next = 2'd0;
                                emit      = 1'b1;
                                pr        = held_r_next;
                                pg        = held_g_next;
                                pb        = sample;
                            end
                        endcase
                    end
                    else
                    begin
                        emit = 1'b1;
                        pr   = sample;
                    end
                end

                if (emit)
                begin
                    res.kind  = KIND_PIXEL;
                    res.col   = col_next;
                    res.row   = row_next[11:0];
                    res.red   = pr;
                    res.green = pg;
                    res.blue  = pb;
                    res_fire  = 1'b1;
                    col_inc   = {1'b0, col_next} + 13'd1;
                    if (col_inc >= img_w_next)
                    begin
                        col_next = '0;
                        row_inc  = row_next + 13'd1;
                        row_next = row_inc;
                        if (row_inc >= img_h_next)
                            phase_next = PH_DONE;
                    end
                    else
                    begin
                        col_next = col_inc[11:0];
                    end
                end

                if (p4raw)
                begin
                    // bits past the image end are dropped with the rest of the byte
                    item_done = (bit_reg == 3'd0) || (phase_next == PH_DONE);
                    bit_next  = item_done ? 3'd7 : bit_reg - 3'd1;
                end
                else
                begin
                    item_done = 1'b1;
                end
            end
            else
            begin
                item_done = 1'b1;
            end

            if (res_fire && res.kind != KIND_ERROR)
            begin
                res.pix      = fmt_next;
                res.width    = img_w_next;
                res.height   = img_h_next;
                res.max_comp = max_next;
            end
            res.last = item_done;
        end
    end

    assign bytes.ready = !in_valid_reg || (step && item_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_sof_reg    <= 1'b0;
            in_byte_reg   <= '0;
            phase_reg     <= PH_MAGIC;
            fmt_reg       <= PIX_BIT;
            ascii_reg     <= 1'b0;
            comment_reg   <= 1'b0;
            line_len_reg  <= '0;
            magic2_reg    <= '0;
            magic_bad_reg <= 1'b0;
            space_reg     <= 1'b0;
            acc_reg       <= '0;
            img_w_reg     <= '0;
            img_h_reg     <= '0;
            max_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            comp_reg      <= '0;
            held_r_reg    <= '0;
            held_g_reg    <= '0;
            bit_reg       <= 3'd7;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (bytes.valid && bytes.ready)
            begin
                in_valid_reg <= 1'b1;
                in_sof_reg   <= bytes.start_of_file;
                in_byte_reg  <= bytes.data_byte;
            end
            else if (step && item_done)
            begin
                in_valid_reg <= 1'b0;
            end

            phase_reg     <= phase_next;
            fmt_reg       <= fmt_next;
            ascii_reg     <= ascii_next;
            comment_reg   <= comment_next;
            line_len_reg  <= line_len_next;
            magic2_reg    <= magic2_next;
            magic_bad_reg <= magic_bad_next;
            space_reg     <= space_next;
            acc_reg       <= acc_next;
            img_w_reg     <= img_w_next;
            img_h_reg     <= img_h_next;
            max_reg       <= max_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            comp_reg      <= comp_next;
            held_r_reg    <= held_r_next;
            held_g_reg    <= held_g_next;
            bit_reg       <= bit_next;

            if (step && res_fire)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= res;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.result_kind   = res_reg.kind;
    assign results.col           = res_reg.col;
    assign results.row           = res_reg.row;
    assign results.red           = res_reg.red;
    assign results.green         = res_reg.green;
    assign results.blue          = res_reg.blue;
    assign results.pixel_type    = res_reg.pix;
    assign results.width         = res_reg.width;
    assign results.height        = res_reg.height;
    assign results.max_component = res_reg.max_comp;
    assign results.err_code      = res_reg.err;
    assign results.last          = res_reg.last;

    a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.result_kind == KIND_ERROR |-> results.err_code != ERR_NONE)
        else $error("error word without error code");

    a_pixel_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.result_kind == KIND_PIXEL
        |-> {1'b0, results.col} < results.width && {1'b0, results.row} < results.height)
        else $error("pixel position outside image");

    a_header_dims: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.result_kind == KIND_HEADER
        |-> results.width != '0 && results.height != '0)
        else $error("header word with zero dimension");

    a_bit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> bit_reg == 3'd7)
        else $error("raw bit index not rewound between bytes");

    a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_fire && res.kind == KIND_ERROR |=> phase_reg == PH_ERR)
        else $error("error word without entering error phase");

endmodule

// ----- tb/tb_pnm_image_stream_parser_unit.sv -----
// Self-checking testbench for the PNM byte stream parser, with a built-in parser predictor.
`timescale 1ns / 1ps

module tb_pnm_image_stream_parser_unit;
    import pnm_pkg::*;

    localparam int HALF_HIGH    = 6;
    localparam int HALF_LOW     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_BYTES = 60;
    localparam int HOLD_CYCLES  = 100;
    localparam int TAIL_CYCLES  = 20;
    localparam int IDLE_LIMIT   = 2000;

    typedef enum logic [2:0] {
        ST_MAGIC_LINE,
        ST_DIM_LINE,
        ST_MAX_LINE,
        ST_PIXELS,
        ST_DONE,
        ST_FAILED
    } parse_state_t;

    class pnm_scoreboard;
        result_t      expected_q[$];
        result_t      byte_results[$];
        int           errors;
        parse_state_t state;
        pix_t         fmt;
        bit           ascii;
        bit           in_comment;
        bit [1:0]     line_len;
        bit [7:0]     magic_char;
        bit           magic_bad;
        bit           saw_space;
        bit [16:0]    acc;
        bit [12:0]    img_w;
        bit [12:0]    img_h;
        bit [15:0]    max_val;
        bit [12:0]    col_pos;
        bit [12:0]    row_pos;
        bit [1:0]     comp_idx;
        bit [15:0]    red_hold;
        bit [15:0]    green_hold;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            state      = ST_MAGIC_LINE;
            fmt        = PIX_BIT;
            ascii      = 1'b0;
            in_comment = 1'b0;
            line_len   = '0;
            magic_char = '0;
            magic_bad  = 1'b0;
            saw_space  = 1'b0;
            acc        = '0;
            img_w      = '0;
            img_h      = '0;
            max_val    = '0;
            col_pos    = '0;
            row_pos    = '0;
            comp_idx   = '0;
            red_hold   = '0;
            green_hold = '0;
        endfunction

        function bit [16:0] add_digit(input bit [16:0] cur, input bit [7:0] b,
                                      input bit [16:0] cap);
            int sum;
            if (b < CH_ZERO || b > CH_NINE)
                return cur;
            sum = int'(cur) * 10 + int'(b - CH_ZERO);
            return (sum > int'(cap)) ? cap : 17'(sum);
        endfunction

        function void push_result(input kind_t kind, input bit [11:0] c, input bit [11:0] r,
                                  input bit [15:0] rd, input bit [15:0] gr,
                                  input bit [15:0] bl, input err_t err, input bit info);
            result_t res;
            res.kind     = kind;
            res.col      = c;
            res.row      = r;
            res.red      = rd;
            res.green    = gr;
            res.blue     = bl;
            res.pix      = info ? fmt : PIX_BIT;
            res.width    = info ? img_w : '0;
            res.height   = info ? img_h : '0;
            res.max_comp = info ? max_val : '0;
            res.err      = err;
            res.last     = 1'b0;
            byte_results.push_back(res);
        endfunction

        function void raise_error(input err_t code);
            push_result(KIND_ERROR, '0, '0, '0, '0, '0, code, 1'b0);
            state = ST_FAILED;
        endfunction

        function void emit_pixel(input bit [15:0] rd, input bit [15:0] gr, input bit [15:0] bl);
            if (state != ST_PIXELS)
                return;
            push_result(KIND_PIXEL, col_pos[11:0], row_pos[11:0], rd, gr, bl, ERR_NONE, 1'b1);
            col_pos++;
            if (col_pos >= img_w)
            begin
                col_pos = '0;
                row_pos++;
                if (row_pos >= img_h)
                    state = ST_DONE;
            end
        endfunction

        function void take_sample(input bit [15:0] v);
            if (fmt == PIX_RGB)
            begin
                if (comp_idx == 0)
                begin
                    red_hold = v;
                    comp_idx = 1;
                end
                else if (comp_idx == 1)
                begin
                    green_hold = v;
                    comp_idx   = 2;
                end
                else
                begin
                    comp_idx = 0;
                    emit_pixel(red_hold, green_hold, v);
                end
            end
            else
                emit_pixel(v, '0, '0);
        endfunction

        function void header_done();
            state    = ST_PIXELS;
            col_pos  = '0;
            row_pos  = '0;
            comp_idx = '0;
            acc      = '0;
            push_result(KIND_HEADER, '0, '0, '0, '0, '0, ERR_NONE, 1'b1);
        endfunction

        function void end_line();
            if (!in_comment)
            begin
                case (state)
                    ST_MAGIC_LINE:
                    begin
                        if (magic_bad || line_len != 2 || magic_char < CH_ONE ||
                            magic_char > CH_SIX)
                            raise_error(ERR_MAGIC);
                        else
                        begin
                            if (magic_char == CH_ONE || magic_char == CH_FOUR)
                                fmt = PIX_BIT;
                            else if (magic_char == CH_THREE || magic_char == CH_SIX)
                                fmt = PIX_RGB;
                            else
                                fmt = PIX_GRAY;
                            ascii = (magic_char <= CH_THREE);
                            state = ST_DIM_LINE;
                        end
                    end
                    ST_DIM_LINE:
                    begin
                        if (!saw_space || img_w == 0 || img_w > MAX_DIM || acc == 0 ||
                            acc > MAX_DIM)
                            raise_error(ERR_DIMS);
                        else
                        begin
                            img_h = acc[12:0];
                            if (fmt == PIX_BIT)
                            begin
                                max_val = '0;
                                header_done();
                            end
                            else
                                state = ST_MAX_LINE;
                        end
                    end
                    ST_MAX_LINE:
                    begin
                        max_val = acc[15:0];
                        header_done();
                    end
                    default: ;
                endcase
            end
            in_comment = 1'b0;
            line_len   = '0;
            magic_bad  = 1'b0;
            saw_space  = 1'b0;
            acc        = '0;
        endfunction

        function void header_byte(input bit [7:0] b);
            if (b == CH_LF)
            begin
                end_line();
                return;
            end
            if (line_len == 0 && b == CH_HASH)
                in_comment = 1'b1;
            if (!in_comment)
            begin
                case (state)
                    ST_MAGIC_LINE:
                    begin
                        if (line_len == 0 && b != CH_P)
                            magic_bad = 1'b1;
                        if (line_len == 1)
                            magic_char = b;
                    end
                    ST_DIM_LINE:
                    begin
                        // only the first space splits width from height
                        if (b == CH_SPACE)
                        begin
                            if (!saw_space)
                            begin
                                img_w     = acc[12:0];
                                acc       = '0;
                                saw_space = 1'b1;
                            end
                        end
                        else
                            acc = add_digit(acc, b, DIM_CAP);
                    end
                    default: acc = add_digit(acc, b, COMP_CAP);
                endcase
            end
            if (line_len < 3)
                line_len++;
        endfunction

        function void pixel_byte(input bit [7:0] b);
            int        i;
            bit [15:0] v;
            if (fmt == PIX_BIT)
            begin
                if (ascii)
                begin
                    if (b != CH_LF)
                        emit_pixel((b == CH_ONE) ? 16'd0 : 16'd1, '0, '0);
                end
                else
                begin
                    // msb first, set bit is black; bits past the image end are dropped
                    for (i = 7; i >= 0; i--)
                        emit_pixel(b[i] ? 16'd0 : 16'd1, '0, '0);
                end
            end
            else if (ascii)
            begin
                if (b == CH_LF)
                begin
                    v   = acc[15:0];
                    acc = '0;
                    take_sample(v);
                end
                else
                    acc = add_digit(acc, b, COMP_CAP);
            end
            else
                take_sample({8'h00, b});
        endfunction

        // Returns 1 when the byte is parsed rather than ignored.
        function bit note_byte(input bit sof, input bit [7:0] b);
            bit      live;
            result_t res;
            byte_results.delete();
            if (sof)
                clear_state();
            live = state inside {ST_MAGIC_LINE, ST_DIM_LINE, ST_MAX_LINE, ST_PIXELS};
            if (state == ST_PIXELS)
                pixel_byte(b);
            else if (live)
                header_byte(b);
            foreach (byte_results[i])
            begin
                res      = byte_results[i];
                res.last = (i == byte_results.size() - 1);
                expected_q.push_back(res);
            end
            return live;
        endfunction

        function void compare_field(input string name, input logic [31:0] want_v,
                                    input logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result word, expected none, actual kind %0d",
                         $time, got.kind);
                return;
            end
            want = expected_q.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("col", want.col, got.col);
            compare_field("row", want.row, got.row);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("pixel_type", want.pix, got.pix);
            compare_field("width", want.width, got.width);
            compare_field("height", want.height, got.height);
            compare_field("max_component", want.max_comp, got.max_comp);
            compare_field("err_code", want.err, got.err);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pnm_byte_if   byte_ch();
    pnm_result_if res_ch();

    pnm_image_stream_parser_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (res_ch)
    );

    pnm_scoreboard sb;
    bit [7:0]      file_bytes[$];
    int            live_sent;
    int            burst_left;
    bit            steady;
    bit            hold_req;

    always
    begin
        clk = 1'b0;
        #(HALF_LOW);
        clk = 1'b1;
        #(HALF_HIGH);
    end

    function void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    function void add_number(input int unsigned v);
        add_text($sformatf("%0d", v));
    endfunction

    function void add_comment();
        int       n;
        bit [7:0] b;
        file_bytes.push_back(CH_HASH);
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            file_bytes.push_back((b == CH_LF) ? CH_HASH : b);
        end
        file_bytes.push_back(CH_LF);
    endfunction

    // Mostly well-formed files with random content; the rest broken headers or noise.
    function void build_random_file();
        int unsigned choice;
        int unsigned digit;
        int unsigned w;
        int unsigned h;
        int unsigned comps;
        int unsigned npix;
        int unsigned cap;
        int unsigned maxv;
        int unsigned n;
        choice = $urandom_range(0, 9);
        if (choice == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 2) == 0)
            add_comment();
        digit = $urandom_range(1, 6);
        if (choice == 1)
        begin
            case ($urandom_range(0, 4))
                0: add_text("P7");
                1: add_text("P0");
                2: add_text("Q3");
                3: add_text("P");
                default: add_text("P25");
            endcase
        end
        else
        begin
            file_bytes.push_back(CH_P);
            file_bytes.push_back(8'(CH_ZERO + digit));
        end
        file_bytes.push_back(CH_LF);
        if ($urandom_range(0, 3) == 0)
            add_comment();
        if (choice == 2)
        begin
            case ($urandom_range(0, 5))
                0: add_text("3");
                1: add_text("0 2");
                2: add_text("2 0");
                3: add_text("4097 1");
                4: add_text("1 99999");
                default: ;
            endcase
            file_bytes.push_back(CH_LF);
            return;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            // largest image; pixel data is cut short
            w = MAX_DIM;
            h = MAX_DIM;
        end
        else
        begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 3);
        end
        add_number(w);
        file_bytes.push_back(CH_SPACE);
        case ($urandom_range(0, 5))
            0:
            begin
                file_bytes.push_back(CH_SPACE);
                add_number(h);
            end
            1:
            begin
                // space inside the height: digits still join
                h = 12;
                add_text("1 2");
            end
            2:
            begin
                add_text("x");
                add_number(h);
            end
            default: add_number(h);
        endcase
        file_bytes.push_back(CH_LF);
        comps = (digit % 3 == 0) ? 3 : 1;
        if (digit % 3 != 1)
        begin
            if ($urandom_range(0, 4) == 0)
                add_comment();
            case ($urandom_range(0, 5))
                0: maxv = 0;
                1: maxv = 1;
                2: maxv = 255;
                3: maxv = 65535;
                4: maxv = 70000;
                default: maxv = $urandom_range(2, 1000);
            endcase
            // an empty maximum line gives maximum 0
            if (maxv != 0)
                add_number(maxv);
            file_bytes.push_back(CH_LF);
        end
        npix = w * h;
        cap  = (digit == 2 || digit == 3) ? 2 : 6;
        if (npix > cap)
            npix = cap;
        else if ($urandom_range(0, 2) == 0)
            npix++;
        case (digit)
            1:
            begin
                repeat (npix)
                begin
                    case ($urandom_range(0, 4))
                        0: file_bytes.push_back(CH_ONE);
                        1: file_bytes.push_back(8'($urandom_range(0, 255)));
                        2:
                        begin
                            file_bytes.push_back(CH_LF);
                            file_bytes.push_back(CH_ONE);
                        end
                        default: file_bytes.push_back(CH_ZERO);
                    endcase
                end
            end
            2, 3:
            begin
                repeat (npix * comps)
                begin
                    if ($urandom_range(0, 5) == 0)
                        add_text("a");
                    case ($urandom_range(0, 4))
                        0: add_number(0);
                        1: add_number(65535);
                        2: add_number(99999);
                        default: add_number($urandom_range(0, 300));
                    endcase
                    file_bytes.push_back(CH_LF);
                end
            end
            4:
                repeat (npix) file_bytes.push_back(8'($urandom_range(0, 255)));
            default:
                repeat (npix * comps) file_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    task automatic send_byte(input bit sof, input bit [7:0] b);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        byte_ch.valid         <= 1'b1;
        byte_ch.start_of_file <= sof;
        byte_ch.data_byte     <= b;
        // inputs only move at the rising edge, so the mid-cycle value decides acceptance
        do
            @(negedge clk);
        while (!byte_ch.ready);
        if (sb.note_byte(sof, b))
            live_sent++;
        @(posedge clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(i == 0, file_bytes[i]);
        file_bytes.delete();
    endtask

    task automatic wait_drain();
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.start_of_file <= 1'b0;
        byte_ch.data_byte     <= '0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        burst_left = 0;
        live_sent  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty magic line
        add_text("\n");
        send_file();
        // bad magic, then bytes ignored until the next file
        add_text("P7\nP1");
        send_file();
        // raw bit image of two pixels, rest of the byte dropped, trailing byte ignored
        add_text("P4\n2 1\n");
        file_bytes.push_back(8'h5a);
        file_bytes.push_back(8'hff);
        send_file();
        // zero height
        add_text("P1\n1 0\n");
        send_file();

        // receiver holds off while the sender streams, then the sender waits it out
        add_text("P5\n4 2\n255\n");
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hff);
        repeat (6) file_bytes.push_back(8'($urandom_range(0, 255)));
        steady   = 1'b1;
        hold_req = 1'b1;
        send_file();
        steady = 1'b0;
        byte_ch.valid <= 1'b0;
        wait_drain();

        live_sent = 0;
        while (live_sent < RANDOM_BYTES)
        begin
            build_random_file();
            send_file();
        end

        byte_ch.valid <= 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall segments, plus one long hold-off on request.
    initial
    begin
        int seg_left;
        int mode;
        int tick;
        seg_left = 0;
        mode     = 0;
        tick     = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 40);
                mode     = $urandom_range(0, 3);
            end
            seg_left--;
            tick++;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 9) < 7);
                2: res_ch.ready <= ($urandom_range(0, 9) < 3);
                default: res_ch.ready <= (tick % 3 != 0);
            endcase
        end
    end

    always @(negedge clk)
    begin
        result_t got;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.kind     = res_ch.result_kind;
            got.col      = res_ch.col;
            got.row      = res_ch.row;
            got.red      = res_ch.red;
            got.green    = res_ch.green;
            got.blue     = res_ch.blue;
            got.pix      = res_ch.pixel_type;
            got.width    = res_ch.width;
            got.height   = res_ch.height;
            got.max_comp = res_ch.max_component;
            got.err      = res_ch.err_code;
            got.last     = res_ch.last;
            sb.check_result(got);
        end
    end

    // Ends the run when no word moves on either channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if (rst_n !== 1'b1 || (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pnm_pkg.sv
sv/pnm_byte_if.sv
sv/pnm_result_if.sv
sv/pnm_image_stream_parser_unit.sv
tb/tb_pnm_image_stream_parser_unit.sv
